// ===== rtl/sp2c_pkg.sv =====
`default_nettype none

package sp2c_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int RANGE_BITS_DEF = 16;

  // fixed field widths
  localparam int FIELD_W   = 16;
  localparam int COORD_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // CORDIC
  localparam int CORDIC_STEPS = 30;
  localparam int FRAC_BITS    = 30;     // Q30
  localparam int Z_W          = 32;     // residual angle, Q30 radians
  localparam int PI_W         = 33;
  localparam logic [PI_W-1:0] PI_Q31 = 33'd6746518852;   // pi * 2^31
  localparam logic [29:0] GAIN_INV_Q30 = 30'd652032874;  // 1/K in Q30
  localparam int COORD_MAX = 65535;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_LOW   = 3'd0,
    REG_RANGE_HIGH  = 3'd1,
    REG_START_ANGLE = 3'd2,
    REG_ANGLE_STEP  = 3'd3,
    REG_INT_PRESENT = 3'd4
  } cfg_reg_e;

  // sideband that rides along the pipe with each sample
  typedef struct packed {
    logic                point_valid;
    logic [1:0]          quad;
    logic [FIELD_W-1:0]  intensity;
    logic                last;
  } tag_t;

  // atan(2^-i) in Q30 radians
  function automatic logic signed [Z_W-1:0] arc_q30(input int i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0:  v = 32'sd843314856;
      1:  v = 32'sd497837829;
      2:  v = 32'sd263043836;
      3:  v = 32'sd133525158;
      4:  v = 32'sd67021686;
      5:  v = 32'sd33543515;
      6:  v = 32'sd16775850;
      7:  v = 32'sd8388437;
      8:  v = 32'sd4194282;
      9:  v = 32'sd2097149;
      10: v = 32'sd1048575;
      11: v = 32'sd524287;
      12: v = 32'sd262143;
      13: v = 32'sd131071;
      14: v = 32'sd65535;
      15: v = 32'sd32767;
      16: v = 32'sd16383;
      17: v = 32'sd8191;
      18: v = 32'sd4095;
      19: v = 32'sd2047;
      20: v = 32'sd1023;
      21: v = 32'sd511;
      22: v = 32'sd255;
      23: v = 32'sd127;
      24: v = 32'sd63;
      25: v = 32'sd31;
      26: v = 32'sd15;
      27: v = 32'sd8;
      28: v = 32'sd4;
      29: v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sp2c_in_if.sv =====
`default_nettype none

interface sp2c_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic [15:0] intensity;
  logic        last_in_scan;

  modport source (output valid, output range_mm, output intensity, output last_in_scan,
                  input ready);
  modport sink   (input valid, input range_mm, input intensity, input last_in_scan,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/sp2c_out_if.sv =====
`default_nettype none

interface sp2c_out_if;
  logic               valid;
  logic               ready;
  logic               point_valid;
  logic signed [16:0] x_mm;
  logic signed [16:0] y_mm;
  logic [15:0]        intensity_out;
  logic               end_of_scan;

  modport source (output valid, output point_valid, output x_mm, output y_mm,
                  output intensity_out, output end_of_scan, input ready);
  modport sink   (input valid, input point_valid, input x_mm, input y_mm,
                  input intensity_out, input end_of_scan, output ready);
endinterface

`default_nettype wire

// ===== rtl/sp2c_front.sv =====
`default_nettype none

module sp2c_front import sp2c_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF,
  localparam int W = RANGE_BITS + 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [FIELD_W-1:0]    range_mm_i,
  input  wire logic [FIELD_W-1:0]    intensity_i,
  input  wire logic                  last_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic signed [W-1:0]        x_o,
  output logic signed [Z_W-1:0]      z_o,
  output tag_t                       tag_o
);

  localparam int MW = ANGLE_BITS - 2;           // residual magnitude width
  localparam int PW = MW + PI_W + 1;            // product plus rounding carry
  localparam int CW = (RANGE_BITS > FIELD_W) ? RANGE_BITS : FIELD_W;
  localparam logic [CW-1:0] RMAX = CW'((64'd1 << RANGE_BITS) - 64'd1);
  localparam logic [ANGLE_BITS-1:0] EIGHTH = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 3));
  localparam logic [PW-1:0] Z_HALF = PW'(64'd1 << (ANGLE_BITS - 1));
  localparam int XPW = RANGE_BITS + 30;

  function automatic logic [ANGLE_BITS-1:0] sx_angle(input logic [FIELD_W-1:0] v);
    logic [31:0] e;
    e = {{16{v[FIELD_W-1]}}, v};
    return e[ANGLE_BITS-1:0];
  endfunction

  function automatic logic [RANGE_BITS-1:0] sat_range(input logic [FIELD_W-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    if (e > RMAX) e = RMAX;
    return e[RANGE_BITS-1:0];
  endfunction

  // configuration registers
  logic [FIELD_W-1:0] range_lo_q, range_hi_q, start_q, step_q;
  logic               int_present_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lo_q    <= '0;
      range_hi_q    <= '1;
      start_q       <= '0;
      step_q        <= '0;
      int_present_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RANGE_LOW:   range_lo_q    <= cfg_data_i;
        REG_RANGE_HIGH:  range_hi_q    <= cfg_data_i;
        REG_START_ANGLE: start_q       <= cfg_data_i;
        REG_ANGLE_STEP:  step_q        <= cfg_data_i;
        REG_INT_PRESENT: int_present_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // beam angle tracking
  logic [ANGLE_BITS-1:0] beam_q, beam_d, angle;
  logic                  at_start_q;
  logic                  accept;

  assign angle  = at_start_q ? sx_angle(start_q) : beam_q;
  assign beam_d = angle + sx_angle(step_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q     <= '0;
      at_start_q <= 1'b1;
    end else if (accept) begin
      beam_q     <= beam_d;
      at_start_q <= last_i;
    end
  end

  // stage 0: range gate, quadrant split
  logic [RANGE_BITS-1:0] r_sat, lo_sat, hi_sat;
  logic                  pt_ok;
  logic [ANGLE_BITS-1:0] a_sum, d, nd;
  logic [1:0]            quad;
  logic                  neg;
  logic [MW-1:0]         mag;

  assign r_sat  = sat_range(range_mm_i);
  assign lo_sat = sat_range(range_lo_q);
  assign hi_sat = sat_range(range_hi_q);
  assign pt_ok  = int_present_q && (lo_sat <= r_sat) && (r_sat <= hi_sat);

  assign a_sum = angle + EIGHTH;
  assign quad  = a_sum[ANGLE_BITS-1 -: 2];
  assign d     = {angle[ANGLE_BITS-1 -: 2] - quad, angle[ANGLE_BITS-3:0]};
  assign neg   = d[ANGLE_BITS-1];
  assign nd    = -d;
  assign mag   = neg ? nd[MW-1:0] : d[MW-1:0];

  logic                  v0_q, v1_q;
  logic                  adv0, adv1;
  logic [RANGE_BITS-1:0] r0_q;
  logic [MW-1:0]         mag0_q;
  logic                  neg0_q;
  tag_t                  tag0_q, tag0_d, tag1_q;

  assign adv1       = !v1_q || ready_i;
  assign adv0       = !v0_q || adv1;
  assign in_ready_o = adv0;
  assign accept     = in_valid_i && adv0;

  always_comb begin
    tag0_d.point_valid = pt_ok;
    tag0_d.quad        = quad;
    tag0_d.intensity   = pt_ok ? intensity_i : '0;
    tag0_d.last        = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      r0_q   <= r_sat;
      mag0_q <= mag;
      neg0_q <= neg;
      tag0_q <= tag0_d;
    end
  end

  // stage 1: residual to Q30 radians, scaled range to Q30 mm
  logic [PW-1:0]        zprod;
  logic [30:0]          zmag;
  logic signed [Z_W-1:0] z1_d, z1_q;
  logic [XPW-1:0]       xprod;
  logic signed [W-1:0]  x1_q;

  assign zprod = PW'(mag0_q) * PW'(PI_Q31) + Z_HALF;
  assign zmag  = zprod[ANGLE_BITS+30:ANGLE_BITS];
  assign z1_d  = neg0_q ? -signed'({1'b0, zmag}) : signed'({1'b0, zmag});
  assign xprod = XPW'(r0_q) * XPW'(GAIN_INV_Q30);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      z1_q   <= z1_d;
      x1_q   <= signed'(W'(xprod));
      tag1_q <= tag0_q;
    end
  end

  assign valid_o = v1_q;
  assign x_o     = x1_q;
  assign z_o     = z1_q;
  assign tag_o   = tag1_q;

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_i |=> at_start_q)
    else $error("scan start flag not set after last sample");

  a_angle_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> beam_q == $past(beam_d))
    else $error("beam angle did not advance by step");

  a_angle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(beam_q) && $stable(at_start_q))
    else $error("angle state moved without a sample");

endmodule

`default_nettype wire

// ===== rtl/sp2c_cordic_cell.sv =====
`default_nettype none

module sp2c_cordic_cell import sp2c_pkg::*; #(
  parameter int STEP = 0,
  parameter int W    = RANGE_BITS_DEF + 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic signed [W-1:0]    x_i,
  input  wire logic signed [W-1:0]    y_i,
  input  wire logic signed [Z_W-1:0]  z_i,
  input  wire tag_t                   tag_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output logic signed [W-1:0]         x_o,
  output logic signed [W-1:0]         y_o,
  output logic signed [Z_W-1:0]       z_o,
  output tag_t                        tag_o
);

  localparam logic signed [Z_W-1:0] ARC = arc_q30(STEP);

  logic                  v_q, adv;
  logic signed [W-1:0]   x_q, y_q, x_d, y_d, dx, dy;
  logic signed [Z_W-1:0] z_q, z_d;
  tag_t                  tag_q;

  assign adv     = !v_q || ready_i;
  assign ready_o = adv;

  // one micro-rotation; direction from the sign of the remaining angle
  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[Z_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ARC;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ARC;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q   <= x_d;
      y_q   <= y_d;
      z_q   <= z_d;
      tag_q <= tag_i;
    end
  end

  assign valid_o = v_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign tag_o   = tag_q;

  a_cell_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !ready_i |=> v_q && $stable(x_q) && $stable(y_q) && $stable(z_q))
    else $error("cordic cell lost data under stall");

endmodule

`default_nettype wire

// ===== rtl/sp2c_back.sv =====
`default_nettype none

module sp2c_back import sp2c_pkg::*; #(
  parameter int W = RANGE_BITS_DEF + 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire logic signed [W-1:0] x_i,
  input  wire logic signed [W-1:0] y_i,
  input  wire tag_t                tag_i,
  sp2c_out_if.source               pnt_o
);

  localparam logic signed [W-1:0] HALF = W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [W-1:0] CMAX = W'(COORD_MAX);

  // round half up to whole mm, clamp to +-COORD_MAX
  function automatic logic signed [COORD_W-1:0] to_mm(input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    if (t > CMAX) t = CMAX;
    if (t < -CMAX) t = -CMAX;
    return t[COORD_W-1:0];
  endfunction

  logic signed [COORD_W-1:0] c, s, px, py;
  logic                      v_q, adv;
  logic                      pv_q, last_q;
  logic signed [COORD_W-1:0] x_q, y_q;
  logic [FIELD_W-1:0]        int_q;

  assign c = to_mm(x_i);
  assign s = to_mm(y_i);

  // undo the quarter-turn split
  always_comb begin
    unique case (tag_i.quad)
      2'd0: begin px = c;  py = s;  end
      2'd1: begin px = -s; py = c;  end
      2'd2: begin px = -c; py = -s; end
      2'd3: begin px = s;  py = -c; end
      default: begin px = '0; py = '0; end
    endcase
  end

  assign adv     = !v_q || pnt_o.ready;
  assign ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pv_q   <= tag_i.point_valid;
      x_q    <= tag_i.point_valid ? px : '0;
      y_q    <= tag_i.point_valid ? py : '0;
      int_q  <= tag_i.intensity;
      last_q <= tag_i.last;
    end
  end

  assign pnt_o.valid         = v_q;
  assign pnt_o.point_valid   = pv_q;
  assign pnt_o.x_mm          = x_q;
  assign pnt_o.y_mm          = y_q;
  assign pnt_o.intensity_out = int_q;
  assign pnt_o.end_of_scan   = last_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !pv_q |-> x_q == '0 && y_q == '0 && int_q == '0)
    else $error("dropped point carries nonzero payload");

  a_coord_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> x_q != COORD_W'(-COORD_MAX - 1) && y_q != COORD_W'(-COORD_MAX - 1))
    else $error("coordinate outside clamp range");

endmodule

`default_nettype wire

// ===== rtl/scan_polar_to_cartesian_top.sv =====
// Channel   Dir  Beat contents                                  Accepted when
// smp_i     in   range_mm, intensity, last_in_scan              valid && ready
// pnt_o     out  point_valid, x_mm, y_mm, intensity_out,
//                end_of_scan                                    valid && ready
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i                cfg_we_i
//
// One sample beat per cycle while pnt_o is ready; the pipe has two front
// stages (range gate and quadrant split, then the two input multipliers), one
// stage per CORDIC micro-rotation (30 cells) and one output register.
// Each stage holds its own valid bit and takes a new beat whenever it is
// empty or its neighbor moves, so bubbles close up behind a stalled output
// and new samples keep entering until the whole chain is full.
// Reset (rst_ni, async, active low) clears stage valids, the registers to
// their defaults and the beam angle; the next sample starts a scan.
`default_nettype none

module scan_polar_to_cartesian_top import sp2c_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int RANGE_BITS = RANGE_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  sp2c_in_if.sink                    smp_i,
  sp2c_out_if.source                 pnt_o
);

  // datapath width: Q30 mm with headroom for CORDIC growth and sign
  localparam int W = RANGE_BITS + 32;

  // chain boundary k sits between cell k-1 and cell k; 0 is the front end
  logic                  c_v [0:CORDIC_STEPS];
  logic                  c_r [0:CORDIC_STEPS];
  logic signed [W-1:0]   c_x [0:CORDIC_STEPS];
  logic signed [W-1:0]   c_y [0:CORDIC_STEPS];
  logic signed [Z_W-1:0] c_z [0:CORDIC_STEPS];
  tag_t                  c_t [0:CORDIC_STEPS];

  sp2c_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .RANGE_BITS (RANGE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (smp_i.valid),
    .in_ready_o  (smp_i.ready),
    .range_mm_i  (smp_i.range_mm),
    .intensity_i (smp_i.intensity),
    .last_i      (smp_i.last_in_scan),
    .valid_o     (c_v[0]),
    .ready_i     (c_r[0]),
    .x_o         (c_x[0]),
    .z_o         (c_z[0]),
    .tag_o       (c_t[0])
  );

  // rotation starts on the x axis
  assign c_y[0] = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    sp2c_cordic_cell #(
      .STEP (k),
      .W    (W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (c_v[k]),
      .ready_o (c_r[k]),
      .x_i     (c_x[k]),
      .y_i     (c_y[k]),
      .z_i     (c_z[k]),
      .tag_i   (c_t[k]),
      .valid_o (c_v[k+1]),
      .ready_i (c_r[k+1]),
      .x_o     (c_x[k+1]),
      .y_o     (c_y[k+1]),
      .z_o     (c_z[k+1]),
      .tag_o   (c_t[k+1])
    );
  end

  // final residual angle is not needed past the last cell
  sp2c_back #(
    .W (W)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_v[CORDIC_STEPS]),
    .ready_o (c_r[CORDIC_STEPS]),
    .x_i     (c_x[CORDIC_STEPS]),
    .y_i     (c_y[CORDIC_STEPS]),
    .tag_i   (c_t[CORDIC_STEPS]),
    .pnt_o   (pnt_o)
  );

endmodule

`default_nettype wire
